### sv/average_color_luminance_defines.svh
// Assertion macros shared by the average colour and luminance block.
`ifndef AVERAGE_COLOR_LUMINANCE_DEFINES_SVH
`define AVERAGE_COLOR_LUMINANCE_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define ACL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define ACL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/acl_pkg.sv
// Types and constants for the average colour and luminance block.
package acl_pkg;

    localparam int CFG_PIX_W  = 25;
    localparam int CFG_FRM_W  = 9;
    localparam int CFG_IDX_W  = 8;
    localparam int CHAN_W     = 8;
    localparam int LUMA_PIX_W = 24;
    localparam int FRM_SUM_W  = 32;
    localparam int FRM_LUMA_W = 48;
    localparam int SET_COL_W  = 16;
    localparam int SET_LUMA_W = 24;
    localparam int OUT_LUMA_W = 16;
    localparam int DIV_W      = 40;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_PER_FRAME = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_SET   = 8'd1;

    // Rec.709 weights, unsigned Q0.16
    localparam logic [15:0] WEIGHT_RED   = 16'd13926;
    localparam logic [15:0] WEIGHT_GREEN = 16'd46884;
    localparam logic [15:0] WEIGHT_BLUE  = 16'd4725;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_DRAIN,
        ST_FRM_START,
        ST_FRM_DIV,
        ST_SET_START,
        ST_SET_DIV
    } state_t;

    typedef struct packed {
        logic pix_take;
        logic div_start;
        logic div_set;
        logic frame_commit;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic frame_end;
        logic set_end;
        logic div_done;
        logic out_busy;
    } status_t;

endpackage

### sv/acl_div.sv
// Restoring divider, one quotient bit per cycle.
module acl_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [acl_pkg::DIV_W-1:0]      dividend,
    input  logic [acl_pkg::CFG_PIX_W-1:0]  divisor,
    output logic [acl_pkg::DIV_W-1:0]      quotient,
    output logic                           done
);

    localparam int DEN_W = acl_pkg::CFG_PIX_W;
    localparam int CNT_W = $clog2(acl_pkg::DIV_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(acl_pkg::DIV_W - 1);

    logic [DEN_W-1:0]          rem_reg, rem_next;
    logic [acl_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [DEN_W:0]            trial;
    logic [DEN_W:0]            diff;
    logic                      ge;

    assign trial = {rem_reg, quo_reg[acl_pkg::DIV_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the top bit drops out
            rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[acl_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

### sv/acl_ctrl.sv
// Sequencer: pixel intake, frame-end and set-end divisions, result hand-off.
`include "average_color_luminance_defines.svh"

module acl_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  acl_pkg::status_t  status_i,
    output acl_pkg::cmd_t     cmd_o
);

    acl_pkg::state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            acl_pkg::ST_RUN: begin
                if (s_tvalid && status_i.frame_end) state_next = acl_pkg::ST_DRAIN;
            end
            acl_pkg::ST_DRAIN:     state_next = acl_pkg::ST_FRM_START;
            acl_pkg::ST_FRM_START: state_next = acl_pkg::ST_FRM_DIV;
            acl_pkg::ST_FRM_DIV: begin
                if (status_i.div_done) begin
                    state_next = status_i.set_end ? acl_pkg::ST_SET_START : acl_pkg::ST_RUN;
                end
            end
            acl_pkg::ST_SET_START: state_next = acl_pkg::ST_SET_DIV;
            acl_pkg::ST_SET_DIV: begin
                if (status_i.div_done && !status_i.out_busy) state_next = acl_pkg::ST_RUN;
            end
            default: state_next = acl_pkg::ST_RUN;
        endcase
    end

    always_comb begin
        cmd_o    = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            acl_pkg::ST_RUN: begin
                s_tready       = 1'b1;
                cmd_o.pix_take = s_tvalid;
            end
            acl_pkg::ST_DRAIN: ;
            acl_pkg::ST_FRM_START: begin
                cmd_o.div_start = 1'b1;
            end
            acl_pkg::ST_FRM_DIV: begin
                cmd_o.frame_commit = status_i.div_done;
            end
            acl_pkg::ST_SET_START: begin
                cmd_o.div_start = 1'b1;
                cmd_o.div_set   = 1'b1;
            end
            acl_pkg::ST_SET_DIV: begin
                cmd_o.out_load = status_i.div_done && !status_i.out_busy;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= acl_pkg::ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    `ACL_ASSERT_IMP(a_load_free, cmd_o.out_load, !status_i.out_busy, "result loaded over a waiting one")
    `ACL_ASSERT_NXT(a_take_end, cmd_o.pix_take && status_i.frame_end, !s_tready, "intake open after frame end")
    `ACL_ASSERT_NXT(a_frame_back, (state_reg == acl_pkg::ST_FRM_DIV) && status_i.div_done && !status_i.set_end, state_reg == acl_pkg::ST_RUN, "no return to intake after frame")

endmodule

### sv/acl_dp.sv
// Datapath: config registers, luminance stage, frame and set sums, dividers, output register.
`include "average_color_luminance_defines.svh"

module acl_dp #(
    parameter int MAX_FRAME_PIXELS = 16777216,
    parameter int MAX_FRAMES       = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic [acl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acl_pkg::CFG_PIX_W-1:0]      cfg_data,
    input  logic [acl_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [acl_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  acl_pkg::cmd_t                      cmd_i,
    output acl_pkg::status_t                   status_o
);

    localparam int PIX_CNT_W = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int FRM_CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int PW = acl_pkg::CFG_PIX_W;
    localparam int FW = acl_pkg::CFG_FRM_W;
    localparam int CW = acl_pkg::CHAN_W;
    localparam logic [PW-1:0] PIX_MAX = PW'(MAX_FRAME_PIXELS);
    localparam logic [FW-1:0] FRM_MAX = FW'(MAX_FRAMES);

    logic [PW-1:0] cfg_pix_reg;
    logic [FW-1:0] cfg_frm_reg;
    logic [PW-1:0] npix;
    logic [FW-1:0] nfrm;

    logic [PIX_CNT_W-1:0] pix_cnt_reg, pix_cnt_next;
    logic [FRM_CNT_W-1:0] frm_cnt_reg, frm_cnt_next;

    logic                           stg_valid_reg;
    logic [CW-1:0]                  stg_red_reg, stg_green_reg, stg_blue_reg;
    logic [acl_pkg::LUMA_PIX_W-1:0] stg_luma_reg, pix_luma;

    logic [acl_pkg::FRM_SUM_W-1:0]  frm_red_sum_reg, frm_red_sum_next;
    logic [acl_pkg::FRM_SUM_W-1:0]  frm_green_sum_reg, frm_green_sum_next;
    logic [acl_pkg::FRM_SUM_W-1:0]  frm_blue_sum_reg, frm_blue_sum_next;
    logic [acl_pkg::FRM_LUMA_W-1:0] frm_luma_sum_reg, frm_luma_sum_next;

    logic [acl_pkg::SET_COL_W-1:0]  set_red_sum_reg, set_red_sum_next;
    logic [acl_pkg::SET_COL_W-1:0]  set_green_sum_reg, set_green_sum_next;
    logic [acl_pkg::SET_COL_W-1:0]  set_blue_sum_reg, set_blue_sum_next;
    logic [acl_pkg::SET_LUMA_W-1:0] set_luma_sum_reg, set_luma_sum_next;

    logic set_phase_reg;
    logic m_tvalid_reg, m_tvalid_next;
    logic [acl_pkg::OUT_DATA_W-1:0] m_tdata_reg;

    logic [acl_pkg::DIV_W-1:0] dvd_red, dvd_green, dvd_blue, dvd_luma;
    logic [acl_pkg::DIV_W-1:0] quo_red, quo_green, quo_blue, quo_luma;
    logic [PW-1:0]             divisor;
    logic                      done_red, done_green, done_blue, done_luma;
    logic [CW-1:0]             in_red, in_green, in_blue;

    assign in_red   = s_tdata[CW-1:0];
    assign in_green = s_tdata[2*CW-1:CW];
    assign in_blue  = s_tdata[3*CW-1:2*CW];

    // zero acts as one, anything above the maximum as the maximum
    always_comb begin
        priority if (cfg_pix_reg == '0) npix = PW'(1);
        else if (cfg_pix_reg > PIX_MAX) npix = PIX_MAX;
        else npix = cfg_pix_reg;
        priority if (cfg_frm_reg == '0) nfrm = FW'(1);
        else if (cfg_frm_reg > FRM_MAX) nfrm = FRM_MAX;
        else nfrm = cfg_frm_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_pix_reg <= PW'(1);
            cfg_frm_reg <= FW'(1);
        end else if (cfg_valid) begin
            if (cfg_index == acl_pkg::CFG_PIXELS_PER_FRAME) cfg_pix_reg <= cfg_data;
            if (cfg_index == acl_pkg::CFG_FRAMES_PER_SET) cfg_frm_reg <= cfg_data[FW-1:0];
        end
    end

    assign status_o.frame_end = ((PW+1)'(pix_cnt_reg) + (PW+1)'(1)) >= {1'b0, npix};
    assign status_o.set_end   = ((FW+1)'(frm_cnt_reg) + (FW+1)'(1)) >= {1'b0, nfrm};
    assign status_o.div_done  = done_red & done_green & done_blue & done_luma;
    assign status_o.out_busy  = m_tvalid_reg && !m_tready;

    assign pix_luma = acl_pkg::LUMA_PIX_W'(in_red)   * acl_pkg::LUMA_PIX_W'(acl_pkg::WEIGHT_RED)
                    + acl_pkg::LUMA_PIX_W'(in_green) * acl_pkg::LUMA_PIX_W'(acl_pkg::WEIGHT_GREEN)
                    + acl_pkg::LUMA_PIX_W'(in_blue)  * acl_pkg::LUMA_PIX_W'(acl_pkg::WEIGHT_BLUE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg <= 1'b0;
        end else begin
            stg_valid_reg <= cmd_i.pix_take;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.pix_take) begin
            stg_red_reg   <= in_red;
            stg_green_reg <= in_green;
            stg_blue_reg  <= in_blue;
            stg_luma_reg  <= pix_luma;
        end
    end

    always_comb begin
        pix_cnt_next       = pix_cnt_reg;
        frm_cnt_next       = frm_cnt_reg;
        frm_red_sum_next   = frm_red_sum_reg;
        frm_green_sum_next = frm_green_sum_reg;
        frm_blue_sum_next  = frm_blue_sum_reg;
        frm_luma_sum_next  = frm_luma_sum_reg;
        set_red_sum_next   = set_red_sum_reg;
        set_green_sum_next = set_green_sum_reg;
        set_blue_sum_next  = set_blue_sum_reg;
        set_luma_sum_next  = set_luma_sum_reg;
        m_tvalid_next      = m_tvalid_reg && !m_tready;

        if (cmd_i.pix_take) begin
            pix_cnt_next = status_o.frame_end ? '0 : pix_cnt_reg + 1'b1;
        end
        if (stg_valid_reg) begin
            frm_red_sum_next   = frm_red_sum_reg + acl_pkg::FRM_SUM_W'(stg_red_reg);
            frm_green_sum_next = frm_green_sum_reg + acl_pkg::FRM_SUM_W'(stg_green_reg);
            frm_blue_sum_next  = frm_blue_sum_reg + acl_pkg::FRM_SUM_W'(stg_blue_reg);
            frm_luma_sum_next  = frm_luma_sum_reg + acl_pkg::FRM_LUMA_W'(stg_luma_reg);
        end
        if (cmd_i.frame_commit) begin
            frm_red_sum_next   = '0;
            frm_green_sum_next = '0;
            frm_blue_sum_next  = '0;
            frm_luma_sum_next  = '0;
            set_red_sum_next   = set_red_sum_reg + quo_red[acl_pkg::SET_COL_W-1:0];
            set_green_sum_next = set_green_sum_reg + quo_green[acl_pkg::SET_COL_W-1:0];
            set_blue_sum_next  = set_blue_sum_reg + quo_blue[acl_pkg::SET_COL_W-1:0];
            set_luma_sum_next  = set_luma_sum_reg + quo_luma[acl_pkg::SET_LUMA_W-1:0];
            frm_cnt_next       = status_o.set_end ? '0 : frm_cnt_reg + 1'b1;
        end
        if (cmd_i.out_load) begin
            set_red_sum_next   = '0;
            set_green_sum_next = '0;
            set_blue_sum_next  = '0;
            set_luma_sum_next  = '0;
            m_tvalid_next      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pix_cnt_reg       <= '0;
            frm_cnt_reg       <= '0;
            frm_red_sum_reg   <= '0;
            frm_green_sum_reg <= '0;
            frm_blue_sum_reg  <= '0;
            frm_luma_sum_reg  <= '0;
            set_red_sum_reg   <= '0;
            set_green_sum_reg <= '0;
            set_blue_sum_reg  <= '0;
            set_luma_sum_reg  <= '0;
            set_phase_reg     <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            pix_cnt_reg       <= pix_cnt_next;
            frm_cnt_reg       <= frm_cnt_next;
            frm_red_sum_reg   <= frm_red_sum_next;
            frm_green_sum_reg <= frm_green_sum_next;
            frm_blue_sum_reg  <= frm_blue_sum_next;
            frm_luma_sum_reg  <= frm_luma_sum_next;
            set_red_sum_reg   <= set_red_sum_next;
            set_green_sum_reg <= set_green_sum_next;
            set_blue_sum_reg  <= set_blue_sum_next;
            set_luma_sum_reg  <= set_luma_sum_next;
            if (cmd_i.div_start) set_phase_reg <= cmd_i.div_set;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    // frame phase divides by the pixel count; luma drops 8 bits first (the 256 in Q8.16 -> Q8.8)
    always_comb begin
        if (cmd_i.div_start ? cmd_i.div_set : set_phase_reg) begin
            dvd_red   = acl_pkg::DIV_W'(set_red_sum_reg);
            dvd_green = acl_pkg::DIV_W'(set_green_sum_reg);
            dvd_blue  = acl_pkg::DIV_W'(set_blue_sum_reg);
            dvd_luma  = acl_pkg::DIV_W'(set_luma_sum_reg);
            divisor   = PW'(nfrm);
        end else begin
            dvd_red   = acl_pkg::DIV_W'(frm_red_sum_reg);
            dvd_green = acl_pkg::DIV_W'(frm_green_sum_reg);
            dvd_blue  = acl_pkg::DIV_W'(frm_blue_sum_reg);
            dvd_luma  = frm_luma_sum_reg[acl_pkg::FRM_LUMA_W-1:8];
            divisor   = npix;
        end
    end

    acl_div u_div_red (
        .aclk, .aresetn, .start(cmd_i.div_start), .dividend(dvd_red),
        .divisor, .quotient(quo_red), .done(done_red)
    );
    acl_div u_div_green (
        .aclk, .aresetn, .start(cmd_i.div_start), .dividend(dvd_green),
        .divisor, .quotient(quo_green), .done(done_green)
    );
    acl_div u_div_blue (
        .aclk, .aresetn, .start(cmd_i.div_start), .dividend(dvd_blue),
        .divisor, .quotient(quo_blue), .done(done_blue)
    );
    acl_div u_div_luma (
        .aclk, .aresetn, .start(cmd_i.div_start), .dividend(dvd_luma),
        .divisor, .quotient(quo_luma), .done(done_luma)
    );

    always_ff @(posedge aclk) begin
        if (cmd_i.out_load) begin
            m_tdata_reg <= {quo_luma[acl_pkg::OUT_LUMA_W-1:0], quo_blue[CW-1:0],
                            quo_green[CW-1:0], quo_red[CW-1:0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `ACL_ASSERT_NXT(a_commit_clear, cmd_i.frame_commit, (pix_cnt_reg == '0) && (frm_red_sum_reg == '0) && (frm_luma_sum_reg == '0), "frame state not cleared after commit")
    `ACL_ASSERT_IMP(a_start_drained, cmd_i.div_start, !stg_valid_reg && !cmd_i.pix_take, "division started with a pixel in flight")

endmodule

### sv/average_color_luminance.sv
// Average colour and Rec.709 luminance over a set of frames: top level.
//
// Pixels enter on the s_ channel, one beat per pixel, red/green/blue in s_tdata.
// Registers are written on the cfg_ channel: index 0 pixels per frame, index 1
// frames per set; other indices are ignored. cfg_ready is always high; write
// only while the block is idle.
// Within a frame one pixel is taken per cycle. The last pixel of a frame
// closes intake while four shared 40-step restoring dividers (one quotient bit
// a cycle) divide the frame sums by the pixel count. At the end of a set the
// same dividers run again over the set sums, then the result appears on m_.
// The result sits in an output register; intake resumes while it waits. If
// the receiver still holds the previous result at the next set end, the
// block waits with intake closed until that beat is taken.
// Reset (aresetn low, synchronous) clears all sums and counters, sets both
// registers to one and drops m_tvalid.
module average_color_luminance #(
    parameter int MAX_FRAME_PIXELS = 16777216,
    parameter int MAX_FRAMES       = 256
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [acl_pkg::IN_DATA_W-1:0]      s_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [acl_pkg::OUT_DATA_W-1:0]     m_tdata,   // avg_red[7:0], avg_green[15:8],
                                                          // avg_blue[23:16], avg_luminance[39:24]
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [acl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acl_pkg::CFG_PIX_W-1:0]      cfg_data
);

    acl_pkg::cmd_t    cmd;
    acl_pkg::status_t status;

    assign cfg_ready = 1'b1;

    acl_ctrl u_ctrl (
        .aclk,
        .aresetn,
        .s_tvalid,
        .s_tready,
        .status_i(status),
        .cmd_o(cmd)
    );

    acl_dp #(
        .MAX_FRAME_PIXELS(MAX_FRAME_PIXELS),
        .MAX_FRAMES(MAX_FRAMES)
    ) u_dp (
        .aclk,
        .aresetn,
        .cfg_valid,
        .cfg_index,
        .cfg_data,
        .s_tdata,
        .m_tvalid,
        .m_tready,
        .m_tdata,
        .cmd_i(cmd),
        .status_o(status)
    );

endmodule
